[hdl/mhpq_pkg.sv]
// Shared constants and types of the min-heap priority queue.
// No dependencies; the queue's top level and its RAM import this package.
package mhpq_pkg;

  localparam int CapacityDef     = 64;
  localparam int PriorityBitsDef = 16;
  localparam int TagBitsDef      = 16;

  // Operation selector carried on the slave-side tuser.
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Result status carried on the master-side tuser.
  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

endpackage

[hdl/mhpq_ram.sv]
// Generic synchronous RAM: one write port and two read ports, read data registered.
// Depends on mhpq_pkg only through the common import convention.
module mhpq_ram #(
  parameter int Width = 32,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  logic [Width-1:0]         wr_data_i,
  input  logic [$clog2(Depth)-1:0] rd0_addr_i,
  output logic [Width-1:0]         rd0_data_o,
  input  logic [$clog2(Depth)-1:0] rd1_addr_i,
  output logic [Width-1:0]         rd1_data_o
);
  import mhpq_pkg::*;

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rd0_q;
  logic [Width-1:0] rd1_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    rd0_q <= mem_q[rd0_addr_i];
    rd1_q <= mem_q[rd1_addr_i];
  end

  assign rd0_data_o = rd0_q;
  assign rd1_data_o = rd1_q;

endmodule

[hdl/min_heap_priority_queue.sv]
// Min-heap priority queue of (tag, priority) entries.
// Uses mhpq_pkg and one mhpq_ram instance that holds the heap array.
// Usage: each item on the slave channel is an enqueue (tuser low, tag and
// priority in tdata) or a dequeue (tuser high, tdata ignored). Every item
// gives exactly one result on the master channel: the status in tuser and
// the dequeued tag, priority and the occupancy after the item in tdata.
// An enqueue into a full queue is dropped and reported; a dequeue from an
// empty queue reports empty. Equal priorities are served in heap order,
// not first in first out.
// One item is processed at a time. An accepted enqueue rises through S_UP, one level per
// step, then writes back in S_WB; a dequeue reads the root and the last entry in S_DN_FIRST,
// sinks through S_DN, one level per step, then writes back. An empty or full report and an
// enqueue into an empty queue go straight to S_WB, a dequeue of the last entry through
// S_DN_FIRST only. The input is ready again in the cycle after the write-back.
// Each sift level is one step: one registered read (both children when sinking), a write.
// A result waits in the output register while a new item is already being
// worked on; the item only stalls at its final write-back when the
// receiver has not yet taken the previous result.
// Reset empties the queue at once; the RAM needs no clearing pass because
// only entries below the occupancy are ever used.
module min_heap_priority_queue #(
  parameter int CAPACITY      = mhpq_pkg::CapacityDef,
  parameter int PRIORITY_BITS = mhpq_pkg::PriorityBitsDef,
  parameter int TAG_BITS      = mhpq_pkg::TagBitsDef
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // tuser: kind
  input  logic s_axis_tuser,
  // tdata: task_tag, priority_req (lowest bit first)
  input  logic [((TAG_BITS+PRIORITY_BITS+7)/8)*8-1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // tuser: status
  output mhpq_pkg::status_e m_axis_tuser,
  // tdata: out_tag, out_priority, occupancy (lowest bit first)
  output logic [((TAG_BITS+PRIORITY_BITS+$clog2(CAPACITY+1)+7)/8)*8-1:0] m_axis_tdata
);
  import mhpq_pkg::*;

  localparam int AW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int EW  = TAG_BITS + PRIORITY_BITS;
  localparam int IX  = AW + 2;
  localparam int ODW = ((TAG_BITS + PRIORITY_BITS + CW + 7) / 8) * 8;

  typedef enum logic [2:0] {
    S_IDLE,
    S_UP,
    S_DN_FIRST,
    S_DN,
    S_WB
  } state_e;

  state_e                 state_q, state_d;
  logic [AW-1:0]          pos_q, pos_d;
  logic [TAG_BITS-1:0]    mv_tag_q, mv_tag_d;
  logic [PRIORITY_BITS-1:0] mv_prio_q, mv_prio_d;
  logic [TAG_BITS-1:0]    res_tag_q, res_tag_d;
  logic [PRIORITY_BITS-1:0] res_prio_q, res_prio_d;
  status_e                status_q, status_d;
  logic [CW-1:0]          lim_q, lim_d;
  logic                   do_wr_q, do_wr_d;
  logic [CW-1:0]          count_q, count_d;
  logic                   m_valid_q, m_valid_d;
  status_e                m_user_q, m_user_d;
  logic [ODW-1:0]         m_data_q, m_data_d;

  logic                   wr_en;
  logic [AW-1:0]          wr_addr;
  logic [EW-1:0]          wr_data;
  logic [AW-1:0]          rd0_addr, rd1_addr;
  logic [EW-1:0]          rd0_data, rd1_data;

  logic [CW-1:0]          cnt_m1;
  logic [AW-1:0]          up_par;
  logic [IX-1:0]          kid_l, kid_r;
  logic                   take_r;
  logic [EW-1:0]          kid_ent;
  logic [AW-1:0]          npos;
  logic [IX-1:0]          nkid_l, nkid_r;
  logic                   out_free;
  logic [TAG_BITS-1:0]    in_tag;
  logic [PRIORITY_BITS-1:0] in_prio;

  assign in_tag  = s_axis_tdata[TAG_BITS-1:0];
  assign in_prio = s_axis_tdata[EW-1:TAG_BITS];

  assign cnt_m1 = count_q - CW'(1);
  assign up_par = AW'((pos_q - AW'(1)) >> 1);
  assign kid_l  = {1'b0, pos_q, 1'b1};
  assign kid_r  = kid_l + IX'(1);
  // The right child wins only when it exists and is strictly smaller.
  assign take_r = (kid_r < IX'(lim_q)) &&
                  (rd1_data[EW-1:TAG_BITS] < rd0_data[EW-1:TAG_BITS]);
  assign kid_ent = take_r ? rd1_data : rd0_data;
  assign npos    = take_r ? kid_r[AW-1:0] : kid_l[AW-1:0];
  assign nkid_l  = {1'b0, npos, 1'b1};
  assign nkid_r  = nkid_l + IX'(1);
  assign out_free = !m_valid_q || m_axis_tready;

  always_comb begin
    state_d    = state_q;
    pos_d      = pos_q;
    mv_tag_d   = mv_tag_q;
    mv_prio_d  = mv_prio_q;
    res_tag_d  = res_tag_q;
    res_prio_d = res_prio_q;
    status_d   = status_q;
    lim_d      = lim_q;
    do_wr_d    = do_wr_q;
    count_d    = count_q;
    m_valid_d  = m_valid_q && !m_axis_tready;
    m_user_d   = m_user_q;
    m_data_d   = m_data_q;
    wr_en      = 1'b0;
    wr_addr    = pos_q;
    wr_data    = {mv_prio_q, mv_tag_q};
    rd0_addr   = '0;
    rd1_addr   = '0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          res_tag_d  = '0;
          res_prio_d = '0;
          if (s_axis_tuser == KIND_ENQ) begin
            if (count_q == CW'(CAPACITY)) begin
              status_d = ST_FULL;
              lim_d    = count_q;
              do_wr_d  = 1'b0;
              state_d  = S_WB;
            end else begin
              status_d  = ST_ENQ;
              mv_tag_d  = in_tag;
              mv_prio_d = in_prio;
              pos_d     = count_q[AW-1:0];
              lim_d     = count_q + CW'(1);
              do_wr_d   = 1'b1;
              rd0_addr  = AW'(cnt_m1 >> 1);
              state_d   = (count_q == '0) ? S_WB : S_UP;
            end
          end else begin
            if (count_q == '0) begin
              status_d = ST_EMPTY;
              lim_d    = '0;
              do_wr_d  = 1'b0;
              state_d  = S_WB;
            end else begin
              status_d = ST_DEQ;
              lim_d    = cnt_m1;
              rd0_addr = '0;
              rd1_addr = cnt_m1[AW-1:0];
              state_d  = S_DN_FIRST;
            end
          end
        end
      end

      S_UP: begin
        // Stop only below a strictly smaller parent; otherwise the parent
        // moves down into the hole.
        if (rd0_data[EW-1:TAG_BITS] < mv_prio_q) begin
          state_d = S_WB;
        end else begin
          wr_en    = 1'b1;
          wr_data  = rd0_data;
          pos_d    = up_par;
          rd0_addr = AW'((up_par - AW'(1)) >> 1);
          if (up_par == '0) begin
            state_d = S_WB;
          end
        end
      end

      S_DN_FIRST: begin
        res_tag_d  = rd0_data[TAG_BITS-1:0];
        res_prio_d = rd0_data[EW-1:TAG_BITS];
        mv_tag_d   = rd1_data[TAG_BITS-1:0];
        mv_prio_d  = rd1_data[EW-1:TAG_BITS];
        pos_d      = '0;
        do_wr_d    = (lim_q != '0);
        rd0_addr   = AW'(1);
        rd1_addr   = AW'(2);
        state_d    = (lim_q == '0) ? S_WB : S_DN;
      end

      S_DN: begin
        if (kid_l >= IX'(lim_q)) begin
          state_d = S_WB;
        end else if (kid_ent[EW-1:TAG_BITS] > mv_prio_q) begin
          state_d = S_WB;
        end else begin
          // The chosen child moves up into the hole; fetch its children.
          wr_en    = 1'b1;
          wr_data  = kid_ent;
          pos_d    = npos;
          rd0_addr = nkid_l[AW-1:0];
          rd1_addr = nkid_r[AW-1:0];
        end
      end

      S_WB: begin
        if (out_free) begin
          wr_en     = do_wr_q;
          count_d   = lim_q;
          m_valid_d = 1'b1;
          m_user_d  = status_q;
          m_data_d  = ODW'({lim_q, res_prio_q, res_tag_q});
          state_d   = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      pos_q      <= '0;
      mv_tag_q   <= '0;
      mv_prio_q  <= '0;
      res_tag_q  <= '0;
      res_prio_q <= '0;
      status_q   <= ST_ENQ;
      lim_q      <= '0;
      do_wr_q    <= 1'b0;
      count_q    <= '0;
      m_valid_q  <= 1'b0;
      m_user_q   <= ST_ENQ;
      m_data_q   <= '0;
    end else begin
      state_q    <= state_d;
      pos_q      <= pos_d;
      mv_tag_q   <= mv_tag_d;
      mv_prio_q  <= mv_prio_d;
      res_tag_q  <= res_tag_d;
      res_prio_q <= res_prio_d;
      status_q   <= status_d;
      lim_q      <= lim_d;
      do_wr_q    <= do_wr_d;
      count_q    <= count_d;
      m_valid_q  <= m_valid_d;
      m_user_q   <= m_user_d;
      m_data_q   <= m_data_d;
    end
  end

  mhpq_ram #(
    .Width (EW),
    .Depth (CAPACITY)
  ) u_heap_ram (
    .clk_i      (clk_i),
    .wr_en_i    (wr_en),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd0_addr_i (rd0_addr),
    .rd0_data_o (rd0_data),
    .rd1_addr_i (rd1_addr),
    .rd1_data_o (rd1_data)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_user_q;
  assign m_axis_tdata  = m_data_q;

  // The queue never holds more entries than the array has rows.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(CAPACITY))
    else $error("entry count beyond capacity");

  // While rising, the hole is never at the root.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_UP) |-> (pos_q != '0))
    else $error("sift-up step with the hole at the root");

  // An accepted item blocks the input until its result is written back.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while an item is in progress");

  // An empty report always comes with zero occupancy.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && (m_user_q == ST_EMPTY)) |-> (m_data_q[EW+CW-1:EW] == '0))
    else $error("empty status with nonzero occupancy");

endmodule
